>>> rtl/snorm_pkg.sv
// Shared types and constants for the stereo peak normalizer.
`timescale 1ns / 1ps
`default_nettype none

package snorm_pkg;

    // Width of the sample and result ports.
    localparam int PORT_W = 16;
    // Default and narrow sample widths.
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int NARROW_BITS = 8;
    // Reset value of the sample width mode register (wide samples).
    localparam logic MODE_RESET = 1'b1;

    typedef enum logic [1:0] {
        ACT_MEASURE = 2'd0,
        ACT_SCALE   = 2'd1,
        ACT_CLEAR   = 2'd2
    } t_action;

    typedef enum logic [3:0] {
        LS_IDLE = 4'b0001,
        LS_MUL  = 4'b0010,
        LS_DIV  = 4'b0100,
        LS_DONE = 4'b1000
    } t_lane_state;

    // Commands from the top level to one channel lane.
    typedef struct packed {
        logic measure;
        logic clear;
        logic start;
        logic take;
        logic mode;
    } t_lane_ctl;

    // Status of one channel lane.
    typedef struct packed {
        logic busy;
        logic done;
    } t_lane_stat;

endpackage

`default_nettype wire

>>> rtl/snorm_lane.sv
// One channel lane: peak tracking and a sequential scale divider.
`timescale 1ns / 1ps
`default_nettype none

module snorm_lane
    import snorm_pkg::*;
#(
    parameter int MAX_SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_lane_ctl         i_ctl,
    input  wire logic [PORT_W-1:0] i_sample,
    output t_lane_stat             o_stat,
    output logic [PORT_W-1:0]      o_result
);

    localparam int W = MAX_SAMPLE_BITS;
    localparam int CNT_W = $clog2(W);

    t_lane_state r_state, n_state;

    logic signed [W-1:0] r_high, r_low;
    logic        [W-1:0] r_mag, r_div, r_fs, r_rem, r_quo;
    logic                r_neg, r_zero, r_sat;
    logic    [CNT_W-1:0] r_cnt;

    logic signed [W-1:0] s;
    logic        [W-1:0] half, mag, div, fs;
    logic                pos, neg, zero;
    logic      [2*W-1:0] prod;
    logic        [W:0]   trial;
    logic                qbit;
    logic        [W-1:0] val;
    logic signed [W-1:0] res;

    // Keep only the bits that the current mode uses, sign-extended.
    always_comb begin
        if (i_ctl.mode) begin
            s = signed'(i_sample[W-1:0]);
        end else begin
            s = W'(signed'(i_sample[NARROW_BITS-1:0]));
        end
        half = i_ctl.mode ? (W'(1) << (W - 1)) : (W'(1) << (NARROW_BITS - 1));
        neg  = s[W-1];
        pos  = !neg && (s != '0);
        mag  = neg ? W'(-s) : W'(s);
        div  = pos ? W'(r_high) : W'(-r_low);
        fs   = pos ? (half - W'(1)) : half;
        zero = (s == '0) || (pos ? (r_high == '0) : (r_low == '0));
    end

    always_comb begin
        prod  = (2*W)'(r_mag) * (2*W)'(r_fs);
        trial = {r_rem, r_quo[W-1]};
        qbit  = (trial >= {1'b0, r_div});
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            LS_IDLE: begin
                if (i_ctl.start) begin
                    n_state = LS_MUL;
                end
            end
            LS_MUL: n_state = LS_DIV;
            LS_DIV: begin
                if (r_cnt == CNT_W'(W - 1)) begin
                    n_state = LS_DONE;
                end
            end
            LS_DONE: begin
                if (i_ctl.take) begin
                    n_state = LS_IDLE;
                end
            end
            default: n_state = LS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LS_IDLE;
            r_high  <= '0;
            r_low   <= '0;
        end else begin
            r_state <= n_state;
            if (i_ctl.clear) begin
                r_high <= '0;
                r_low  <= '0;
            end else if (i_ctl.measure) begin
                if (s > r_high) begin
                    r_high <= s;
                end
                if (s < r_low) begin
                    r_low <= s;
                end
            end
        end
    end

    // The quotient stays below full scale unless the sample reaches its peak,
    // so the high half of the product is already smaller than the divisor.
    always_ff @(posedge i_clk) begin
        if (r_state == LS_IDLE && i_ctl.start) begin
            r_mag  <= mag;
            r_div  <= div;
            r_fs   <= fs;
            r_neg  <= neg;
            r_zero <= zero;
            r_sat  <= (mag >= div);
        end
        if (r_state == LS_MUL) begin
            r_rem <= prod[2*W-1:W];
            r_quo <= prod[W-1:0];
            r_cnt <= '0;
        end else if (r_state == LS_DIV) begin
            r_rem <= qbit ? W'(trial - {1'b0, r_div}) : trial[W-1:0];
            r_quo <= {r_quo[W-2:0], qbit};
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_comb begin
        if (r_zero) begin
            val = '0;
        end else if (r_sat) begin
            val = r_fs;
        end else begin
            val = r_quo;
        end
        res      = r_neg ? signed'(W'(-val)) : signed'(val);
        o_result = PORT_W'(res);
    end

    assign o_stat.busy = (r_state != LS_IDLE);
    assign o_stat.done = (r_state == LS_DONE);

endmodule

`default_nettype wire

>>> rtl/stereo_peak_normalizer.sv
// After a scale transaction is accepted, o_stall stays high until its result is loaded into the
// output register, which waits while a pending result is stalled; each channel lane steps through
// multiply, bit-serial divide and done states. Measure and clear transactions never raise o_stall.
// A finished result waits in the output register while the next transaction is accepted.
// Synchronous active-low reset clears the peaks, the lanes and the output valid,
// and sets the sample width mode to wide samples.
`timescale 1ns / 1ps
`default_nettype none

module stereo_peak_normalizer
    import snorm_pkg::*;
#(
    parameter int MAX_SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_wdata,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_action,
    input  wire logic [PORT_W-1:0] i_right_sample,
    input  wire logic [PORT_W-1:0] i_left_sample,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [PORT_W-1:0]      o_right_scaled,
    output logic [PORT_W-1:0]      o_left_scaled
);

    logic r_mode;
    logic r_out_valid;
    logic [PORT_W-1:0] r_right_out, r_left_out;

    t_lane_ctl  lane_ctl;
    t_lane_stat right_stat, left_stat;
    logic [PORT_W-1:0] right_res, left_res;
    logic in_take, load;

    assign o_stall = right_stat.busy | left_stat.busy;
    assign in_take = i_valid & !o_stall;

    // Both lanes run in lockstep; the merge stage waits for both anyway.
    assign load = right_stat.done & left_stat.done & (!r_out_valid | !i_stall);

    always_comb begin
        lane_ctl.measure = in_take && (i_action == ACT_MEASURE);
        lane_ctl.clear   = in_take && (i_action == ACT_CLEAR);
        lane_ctl.start   = in_take && (i_action == ACT_SCALE);
        lane_ctl.take    = load;
        lane_ctl.mode    = r_mode;
    end

    snorm_lane #(
        .MAX_SAMPLE_BITS(MAX_SAMPLE_BITS)
    ) u_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_sample (i_right_sample),
        .o_stat   (right_stat),
        .o_result (right_res)
    );

    snorm_lane #(
        .MAX_SAMPLE_BITS(MAX_SAMPLE_BITS)
    ) u_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_sample (i_left_sample),
        .o_stat   (left_stat),
        .o_result (left_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_right_out <= right_res;
            r_left_out  <= left_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_right_scaled = r_right_out;
    assign o_left_scaled  = r_left_out;

endmodule

`default_nettype wire

>>> tb/tb_stereo_peak_normalizer.sv
// Self-checking testbench for the stereo peak normalizer with a frame scoreboard.
`timescale 1ns / 1ps

module tb_stereo_peak_normalizer;
    import snorm_pkg::*;

    localparam int MAX_SAMPLE_BITS = DEF_SAMPLE_BITS;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Tracks the peaks and width mode, and holds the frames the block still owes.
    class norm_scoreboard;
        bit wide_mode;
        int right_high, right_low, left_high, left_low;
        logic [PORT_W-1:0] owed_right[$];
        logic [PORT_W-1:0] owed_left[$];
        int mismatches;

        function new();
            wide_mode = MODE_RESET;
            right_high = 0;
            right_low = 0;
            left_high = 0;
            left_low = 0;
            mismatches = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
        endfunction

        // Only the low bits of the current sample width count, sign-extended.
        function int fit_sample(logic [PORT_W-1:0] raw);
            if (wide_mode) return int'($signed(raw));
            return int'($signed(raw[NARROW_BITS-1:0]));
        endfunction

        function logic [PORT_W-1:0] scaled(int s, int high, int low);
            int unsigned fs_pos, fs_neg, mag, peak, q;
            fs_neg = wide_mode ? 32'd32768 : 32'd128;
            fs_pos = fs_neg - 1;
            if (s > 0 && high > 0) begin
                mag = s;
                peak = high;
                q = (mag * fs_pos) / peak;
                if (q > fs_pos) q = fs_pos;
                return q[PORT_W-1:0];
            end
            if (s < 0 && low < 0) begin
                mag = -s;
                peak = -low;
                q = (mag * fs_neg) / peak;
                if (q > fs_neg) q = fs_neg;
                return 16'(-q);
            end
            return '0;
        endfunction

        function void note_input(logic [1:0] act, logic [PORT_W-1:0] r_raw,
                                 logic [PORT_W-1:0] l_raw);
            int r, l;
            r = fit_sample(r_raw);
            l = fit_sample(l_raw);
            case (act)
                ACT_MEASURE: begin
                    if (r > right_high) right_high = r;
                    if (r < right_low) right_low = r;
                    if (l > left_high) left_high = l;
                    if (l < left_low) left_low = l;
                end
                ACT_SCALE: begin
                    owed_right.push_back(scaled(r, right_high, right_low));
                    owed_left.push_back(scaled(l, left_high, left_low));
                end
                ACT_CLEAR: begin
                    right_high = 0;
                    right_low = 0;
                    left_high = 0;
                    left_low = 0;
                end
                default: ;
            endcase
        endfunction

        function void check_frame(logic [PORT_W-1:0] r, logic [PORT_W-1:0] l);
            logic [PORT_W-1:0] want_r, want_l;
            if (owed_right.size() == 0) begin
                flag($sformatf("frame %0d/%0d emitted with none owed",
                               $signed(r), $signed(l)));
                return;
            end
            want_r = owed_right.pop_front();
            want_l = owed_left.pop_front();
            if (r !== want_r)
                flag($sformatf("right_scaled: expected %0d, got %0d",
                               $signed(want_r), $signed(r)));
            if (l !== want_l)
                flag($sformatf("left_scaled: expected %0d, got %0d",
                               $signed(want_l), $signed(l)));
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_wdata;
    logic              i_valid;
    logic              o_stall;
    logic [1:0]        i_action;
    logic [PORT_W-1:0] i_right_sample;
    logic [PORT_W-1:0] i_left_sample;
    logic              o_valid;
    logic              i_stall;
    logic [PORT_W-1:0] o_right_scaled;
    logic [PORT_W-1:0] o_left_scaled;

    norm_scoreboard sb;
    int burst_left;
    int stall_style;
    int style_left;

    stereo_peak_normalizer #(
        .MAX_SAMPLE_BITS(MAX_SAMPLE_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_right_sample(i_right_sample),
        .i_left_sample (i_left_sample),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_right_scaled(o_right_scaled),
        .o_left_scaled (o_left_scaled)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Sends one transaction; the sender often idles between bursts of random length.
    task automatic send_frame(input logic [1:0] act, input logic [PORT_W-1:0] r,
                              input logic [PORT_W-1:0] l);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_action <= act;
        i_right_sample <= r;
        i_left_sample <= l;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(act, r, l);
    endtask

    // The mode may only change once the block has drained its last scale transaction.
    task automatic write_width_mode(input bit m);
        i_valid <= 1'b0;
        burst_left = 0;
        while (sb.owed_right.size() != 0) @(posedge i_clk);
        repeat (MAX_SAMPLE_BITS + 6) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.wide_mode = m;
    endtask

    function automatic logic [PORT_W-1:0] rand_in(int amp);
        int s;
        logic [PORT_W-1:0] v;
        s = int'($urandom_range(0, 2 * amp - 1)) - amp;
        v = 16'(s);
        // Junk above the narrow width must be ignored by the block.
        if (!sb.wide_mode && $urandom_range(0, 9) == 0) v[PORT_W-1:NARROW_BITS] = 8'($urandom);
        return v;
    endfunction

    task automatic run_random_phase(input int n_items);
        int done_items, full_amp, top_bit, amp_r, amp_l, meas_n, scale_n, sc_r, sc_l;
        logic [1:0] act;
        done_items = 0;
        full_amp = sb.wide_mode ? 32768 : 128;
        top_bit = sb.wide_mode ? MAX_SAMPLE_BITS - 1 : NARROW_BITS - 1;
        while (done_items < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                act = 2'($urandom_range(0, 3));
                send_frame(act, 16'($urandom), 16'($urandom));
                if (act != ACT_UNUSED) done_items++;
            end else begin
                if ($urandom_range(0, 9) < 7) begin
                    send_frame(ACT_CLEAR, rand_in(full_amp), rand_in(full_amp));
                    done_items++;
                end
                amp_r = $urandom_range(1, 1 << $urandom_range(0, top_bit));
                amp_l = $urandom_range(1, 1 << $urandom_range(0, top_bit));
                sc_r = ($urandom_range(0, 3) == 0) ? full_amp : amp_r;
                sc_l = ($urandom_range(0, 3) == 0) ? full_amp : amp_l;
                meas_n = $urandom_range(0, 10);
                scale_n = $urandom_range(1, 12);
                repeat (meas_n) send_frame(ACT_MEASURE, rand_in(amp_r), rand_in(amp_l));
                repeat (scale_n) send_frame(ACT_SCALE, rand_in(sc_r), rand_in(sc_l));
                done_items += meas_n + scale_n;
            end
        end
    endtask

    // Output side: checks accepted frames and stalls in styles that change over time.
    initial begin
        i_stall <= 1'b0;
        style_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) sb.check_frame(o_right_scaled, o_left_scaled);
            if (style_left == 0) begin
                stall_style = $urandom_range(0, 3);
                style_left = $urandom_range(40, 300);
            end
            style_left--;
            case (stall_style)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 4) == 0);
                2: i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= style_left[2];
            endcase
        end
    end

    initial begin
        int guard;
        sb = new();
        burst_left = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= 1'b0;
        i_valid <= 1'b0;
        i_action <= ACT_MEASURE;
        i_right_sample <= '0;
        i_left_sample <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_width_mode(1'b1);
        // Peaks are still zero, so nothing can be scaled up.
        send_frame(ACT_SCALE, 16'd100, -16'sd100);
        send_frame(ACT_MEASURE, 16'h7fff, 16'h8000);
        send_frame(ACT_MEASURE, 16'h8000, 16'h7fff);
        send_frame(ACT_SCALE, 16'h7fff, 16'h8000);
        send_frame(ACT_SCALE, 16'h8000, 16'h7fff);
        send_frame(ACT_SCALE, 16'h0000, 16'h0000);
        send_frame(ACT_SCALE, 16'h0001, 16'hffff);
        send_frame(ACT_UNUSED, 16'hffff, 16'h8000);
        send_frame(ACT_CLEAR, 16'h1234, 16'h5678);
        // One-sided peaks: the opposite sign has nothing to scale against.
        send_frame(ACT_MEASURE, 16'd100, -16'sd50);
        send_frame(ACT_SCALE, 16'd200, -16'sd100);
        send_frame(ACT_SCALE, -16'sd5, 16'd7);
        send_frame(ACT_SCALE, 16'd50, -16'sd25);

        // Narrow mode applied to peaks measured in wide mode.
        write_width_mode(1'b0);
        send_frame(ACT_SCALE, 16'h1234, 16'hff80);
        send_frame(ACT_CLEAR, 16'h0000, 16'h0000);
        send_frame(ACT_MEASURE, 16'h017f, 16'h0080);
        send_frame(ACT_MEASURE, 16'hff80, 16'h7f7f);
        send_frame(ACT_SCALE, 16'h007f, 16'hff80);
        send_frame(ACT_SCALE, 16'hff80, 16'h007f);
        send_frame(ACT_SCALE, 16'h0040, 16'hffc0);
        send_frame(ACT_UNUSED, 16'h00ff, 16'hff00);

        for (int phase = 0; phase < 5; phase++) begin
            write_width_mode(phase[0] ? 1'b0 : 1'b1);
            run_random_phase(265);
        end

        i_valid <= 1'b0;
        for (guard = 0; guard < 20000 && sb.owed_right.size() != 0; guard++)
            @(posedge i_clk);
        repeat (MAX_SAMPLE_BITS + 10) @(posedge i_clk);
        if (sb.owed_right.size() != 0)
            sb.flag($sformatf("%0d frames never emitted", sb.owed_right.size()));
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/snorm_pkg.sv
rtl/snorm_lane.sv
rtl/stereo_peak_normalizer.sv
tb/tb_stereo_peak_normalizer.sv
